// ----- hw/rtl/mbs_pkg.sv -----
package mbs_pkg;

  localparam int unsigned REG_COUNT_DEF        = 256;
  localparam int unsigned LED_INDEX_DEF        = 0;
  localparam int unsigned BEEP_INDEX_DEF       = 1;
  localparam int unsigned TEMP_LIMIT_INDEX_DEF = 4;
  localparam int unsigned HUMI_LIMIT_INDEX_DEF = 5;
  localparam int unsigned ADDR_REG_INDEX_DEF   = 7;

  localparam logic [7:0]  FN_READ    = 8'h03;
  localparam logic [7:0]  FN_WRITE   = 8'h06;
  localparam logic [15:0] MAX_READ   = 16'd125;
  localparam logic [15:0] TEMP_RESET = 16'd300;
  localparam logic [15:0] HUMI_RESET = 16'd800;
  localparam logic [15:0] ADDR_RESET = 16'h0001;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [3:0]  FRAME_LEN  = 4'd8;
  localparam logic [3:0]  OVF_COUNT  = 4'd9;

  typedef logic [7:0][7:0] frame_t;

  typedef struct packed {
    logic clr;
    logic en;
    logic din;
  } crc_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_EVAL,
    ST_NEXT,
    ST_RDREQ,
    ST_RDCAP,
    ST_APPEND,
    ST_CRC,
    ST_AFTER,
    ST_PAD,
    ST_OUT
  } state_e;

endpackage

// ----- hw/rtl/mbs_ram.sv -----
module mbs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/mbs_crc.sv -----
module mbs_crc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbs_pkg::crc_ctl_t   ctl_i,
  output logic [15:0]         crc_o
);
  import mbs_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic        fb;

  // one bit per cycle while en is set, lsb first, reflected polynomial
  always_comb begin
    fb    = crc_q[0] ^ ctl_i.din;
    crc_d = crc_q;
    if (ctl_i.clr) begin
      crc_d = CRC_INIT;
    end else if (ctl_i.en) begin
      crc_d = {1'b0, crc_q[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// ----- hw/rtl/mbs_rx.sv -----
module mbs_rx (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_en_i,
  input  logic [7:0]      byte_i,
  input  logic            frame_end_i,
  output mbs_pkg::frame_t frame_o,
  output logic            done_o
);
  import mbs_pkg::*;

  logic [3:0] cnt_q, cnt_d;
  frame_t     frame_q;

  always_comb begin
    cnt_d = cnt_q;
    if (byte_en_i) begin
      cnt_d = (cnt_q < FRAME_LEN) ? cnt_q + 4'd1 : OVF_COUNT;
      if (frame_end_i) begin
        cnt_d = '0;
      end
    end
  end

  // frame ends on exactly the eighth byte
  assign done_o = byte_en_i && frame_end_i && (cnt_q == FRAME_LEN - 4'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_en_i && (cnt_q < FRAME_LEN)) begin
      frame_q[cnt_q[2:0]] <= byte_i;
    end
  end

  assign frame_o = frame_q;

endmodule

// ----- hw/rtl/modbus_rtu_slave_frame_handler.sv -----
// modbus rtu slave frame handler with a 16-bit holding register map
//
// input channel (in_valid_i / in_stall_o): one item is either a received line
// byte (operation 0, frame_end on the last byte) or a local register write
// (operation 1). a byte is taken while in_stall_o is low. after the eighth
// byte of a frame that ends, the block checks the crc bit-serially and holds
// in_stall_o high until the whole reply has left (or the frame is refused).
// output channel (out_valid_i / out_stall_i): the reply goes out in groups of
// up to eight bytes, first byte in bits 7:0, tx_last_o on the final group.
// every body byte runs through a one-bit-per-cycle crc unit, and the high
// byte of a register first waits on the registered map read; the two crc
// bytes follow the body, and the last group is padded with zero bytes.
// while out_stall_i is high the current group is held unchanged and the
// sequencer waits.
// reset clears the frame byte count and all map valid bits: an entry that was
// never written reads as its reset value (zero, or the alarm limits and
// slave address), so no clearing pass is needed.
module modbus_rtu_slave_frame_handler
  import mbs_pkg::*;
#(
  parameter int unsigned REG_COUNT        = REG_COUNT_DEF,
  parameter int unsigned LED_INDEX        = LED_INDEX_DEF,
  parameter int unsigned BEEP_INDEX       = BEEP_INDEX_DEF,
  parameter int unsigned TEMP_LIMIT_INDEX = TEMP_LIMIT_INDEX_DEF,
  parameter int unsigned HUMI_LIMIT_INDEX = HUMI_LIMIT_INDEX_DEF,
  parameter int unsigned ADDR_REG_INDEX   = ADDR_REG_INDEX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  input  logic [7:0]  local_index_i,
  input  logic [15:0] local_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] tx_bytes_o,
  output logic [3:0]  tx_count_o,
  output logic        tx_last_o
);

  localparam int unsigned IW = $clog2(REG_COUNT);

  state_e state_q, state_d;

  // input side
  logic   in_acc, rx_en, rx_done, loc_we;
  frame_t frame;

  assign in_acc = in_valid_i && !in_stall_o;
  assign rx_en  = in_acc && !operation_i;
  assign loc_we = in_acc && operation_i && (9'(local_index_i) < 9'(REG_COUNT));

  mbs_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_en_i   (rx_en),
    .byte_i      (rx_byte_i),
    .frame_end_i (frame_end_i),
    .frame_o     (frame),
    .done_o      (rx_done)
  );

  // frame fields
  logic [15:0] start_w, num_w;
  assign start_w = {frame[2], frame[3]};
  assign num_w   = {frame[4], frame[5]};

  // crc unit
  crc_ctl_t    crc_ctl;
  logic [15:0] crc;

  mbs_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .crc_o  (crc)
  );

  // sequencer registers
  logic [7:0]  k_q;
  logic [2:0]  bit_q;
  logic [7:0]  body_q;
  logic        rd_mode_q;
  logic [IW-1:0] rd_ptr_q;
  logic [15:0] hold_q;
  logic [7:0]  sh_q;
  logic [63:0] pack_q;
  logic [3:0]  cnt_q, fill_q;
  logic        lastgrp_q;
  logic [7:0]  slave_q;

  // frame checks
  logic addr_ok, crc_ok, read_ok, write_ok, writable;
  assign addr_ok  = frame[0] == slave_q;
  assign crc_ok   = crc == {frame[7], frame[6]};
  assign writable = (start_w == 16'(LED_INDEX)) || (start_w == 16'(BEEP_INDEX)) ||
                    (start_w == 16'(TEMP_LIMIT_INDEX)) ||
                    (start_w == 16'(HUMI_LIMIT_INDEX)) ||
                    (start_w == 16'(ADDR_REG_INDEX));
  assign read_ok  = addr_ok && crc_ok && (frame[1] == FN_READ) && (num_w != 16'd0) &&
                    (num_w <= MAX_READ) &&
                    ((17'(start_w) + 17'(num_w)) <= 17'(REG_COUNT));
  assign write_ok = addr_ok && crc_ok && (frame[1] == FN_WRITE) &&
                    (17'(start_w) < 17'(REG_COUNT)) && writable;

  // register map: ram plus per-entry valid bits for reset values
  logic            map_we;
  logic [IW-1:0]   map_waddr;
  logic [15:0]     map_wdata;
  logic [15:0]     ram_rdata, map_rdata, rst_val;
  logic [REG_COUNT-1:0] vld_q;
  logic            rvld_q;
  logic [IW-1:0]   raddr_q;
  logic [7:0]      map_widx;

  assign map_we    = loc_we || ((state_q == ST_EVAL) && write_ok);
  assign map_widx  = loc_we ? local_index_i : start_w[7:0];
  assign map_waddr = map_widx[IW-1:0];
  assign map_wdata = loc_we ? local_value_i : num_w;

  mbs_ram #(
    .WIDTH (16),
    .DEPTH (REG_COUNT)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // where indices coincide the address reset wins, then humidity, then temperature
  always_comb begin
    rst_val = 16'h0000;
    if (9'(raddr_q) == 9'(ADDR_REG_INDEX)) begin
      rst_val = ADDR_RESET;
    end else if (9'(raddr_q) == 9'(HUMI_LIMIT_INDEX)) begin
      rst_val = HUMI_RESET;
    end else if (9'(raddr_q) == 9'(TEMP_LIMIT_INDEX)) begin
      rst_val = TEMP_RESET;
    end
  end

  assign map_rdata = rvld_q ? ram_rdata : rst_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      slave_q <= ADDR_RESET[7:0];
    end else if (map_we) begin
      vld_q[map_waddr] <= 1'b1;
      if (map_widx == 8'(ADDR_REG_INDEX)) begin
        slave_q <= map_wdata[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RDREQ) begin
      rvld_q  <= vld_q[rd_ptr_q];
      raddr_q <= rd_ptr_q;
    end
  end

  // current reply byte
  logic [7:0] dj;
  logic       data_hi, last_byte;
  logic [7:0] cur_byte;

  assign dj        = k_q - 8'd3;
  assign data_hi   = rd_mode_q && (k_q >= 8'd3) && (k_q < body_q) && !dj[0];
  assign last_byte = k_q == (body_q + 8'd1);

  always_comb begin
    cur_byte = 8'h00;
    if (k_q < body_q) begin
      if (!rd_mode_q || k_q < 8'd2) begin
        cur_byte = frame[k_q[2:0]];
      end else if (k_q == 8'd2) begin
        cur_byte = {frame[5][6:0], 1'b0};
      end else begin
        cur_byte = dj[0] ? hold_q[7:0] : hold_q[15:8];
      end
    end else if (k_q == body_q) begin
      cur_byte = crc[7:0];
    end else begin
      cur_byte = crc[15:8];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (rx_done) state_d = ST_CHK;
      ST_CHK:    if (k_q == 8'd5 && bit_q == 3'd7) state_d = ST_EVAL;
      ST_EVAL:   state_d = (read_ok || write_ok) ? ST_NEXT : ST_IDLE;
      ST_NEXT:   state_d = data_hi ? ST_RDREQ : ST_APPEND;
      ST_RDREQ:  state_d = ST_RDCAP;
      ST_RDCAP:  state_d = ST_APPEND;
      ST_APPEND: state_d = (k_q < body_q) ? ST_CRC : ST_AFTER;
      ST_CRC:    if (bit_q == 3'd7) state_d = ST_AFTER;
      ST_AFTER: begin
        if (cnt_q == 4'd8) begin
          state_d = ST_OUT;
        end else if (last_byte) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_PAD:    if (fill_q == 4'd7) state_d = ST_OUT;
      ST_OUT:    if (!out_stall_i) state_d = lastgrp_q ? ST_IDLE : ST_NEXT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    crc_ctl     = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        crc_ctl.clr = 1'b1;
      end
      ST_CHK: begin
        crc_ctl.en  = 1'b1;
        crc_ctl.din = frame[k_q[2:0]][bit_q];
      end
      ST_EVAL:  crc_ctl.clr = 1'b1;
      ST_CRC: begin
        crc_ctl.en  = 1'b1;
        crc_ctl.din = sh_q[bit_q];
      end
      ST_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      bit_q   <= '0;
      cnt_q   <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          k_q   <= '0;
          bit_q <= '0;
        end
        ST_CHK: begin
          bit_q <= bit_q + 3'd1;
          if (bit_q == 3'd7) k_q <= k_q + 8'd1;
        end
        ST_EVAL: begin
          k_q    <= '0;
          cnt_q  <= '0;
          fill_q <= '0;
        end
        ST_APPEND: begin
          cnt_q  <= cnt_q + 4'd1;
          fill_q <= fill_q + 4'd1;
          bit_q  <= '0;
        end
        ST_CRC:   bit_q <= bit_q + 3'd1;
        ST_AFTER: k_q <= k_q + 8'd1;
        ST_PAD:   fill_q <= fill_q + 4'd1;
        ST_OUT: begin
          if (!out_stall_i) begin
            cnt_q  <= '0;
            fill_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_EVAL: begin
        rd_mode_q <= read_ok;
        body_q    <= read_ok ? 8'd3 + {frame[5][6:0], 1'b0} : 8'd6;
        rd_ptr_q  <= start_w[IW-1:0];
      end
      ST_RDREQ:  rd_ptr_q <= rd_ptr_q + IW'(1);
      ST_RDCAP:  hold_q <= map_rdata;
      ST_APPEND: begin
        pack_q <= {cur_byte, pack_q[63:8]};
        sh_q   <= cur_byte;
      end
      ST_AFTER:  lastgrp_q <= last_byte;
      ST_PAD:    pack_q <= {8'h00, pack_q[63:8]};
      default: ;
    endcase
  end

  assign tx_bytes_o = pack_q;
  assign tx_count_o = cnt_q;
  assign tx_last_o  = lastgrp_q;

endmodule

// ----- hw/rtl/mbs_checker.sv -----
module mbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] tx_bytes_o,
  input logic [3:0]  tx_count_o,
  input logic        tx_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tx_bytes_o) &&
    $stable(tx_count_o) && $stable(tx_last_o))
    else $error("stalled reply group changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tx_count_o != 4'd0) && (tx_count_o <= 4'd8))
    else $error("reply group byte count out of range");

  a_partial_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (tx_count_o < 4'd8) |-> tx_last_o)
    else $error("partial group not marked last");

  a_busy_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while reply pending");

  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("reply right after an accepted item");

endmodule

bind modbus_rtu_slave_frame_handler mbs_checker u_mbs_checker (.*);
